FILE: rtl/b64d_pkg.sv
package b64d_pkg;

    localparam int SEXTET_W    = 6;
    localparam int CHAR_W      = 8;
    localparam int COUNT_W     = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [1:0] POS_FIRST = 2'd0;

    // One classified character: either a sextet or a message terminator
    typedef struct packed {
        logic                is_end;
        logic [SEXTET_W-1:0] sextet;
    } sym_t;

    function automatic sym_t sextet_of(input logic [CHAR_W-1:0] c);
        sym_t r;
        r.is_end = 1'b0;
        r.sextet = '0;
        if (c inside {["A":"Z"]}) begin
            r.sextet = SEXTET_W'(c - 8'd65);
        end
        else if (c inside {["a":"z"]}) begin
            r.sextet = SEXTET_W'(c - 8'd97 + 8'd26);
        end
        else if (c inside {["0":"9"]}) begin
            r.sextet = SEXTET_W'(c - 8'd48 + 8'd52);
        end
        else if (c == 8'd43) begin
            r.sextet = SEXTET_W'(62);
        end
        else if (c == 8'd47) begin
            r.sextet = SEXTET_W'(63);
        end
        else begin
            r.is_end = 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: rtl/b64d_front.sv
module b64d_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [b64d_pkg::CHAR_W-1:0]  code_char,
    input  logic                         char_valid,
    output logic                         char_stall,
    output b64d_pkg::sym_t               push_sym,
    output logic                         push,
    input  logic                         full
);
    import b64d_pkg::*;

    logic fr_valid_reg;
    logic fr_valid_next;
    sym_t fr_sym_reg;
    logic accept;

    assign char_stall = fr_valid_reg && full;
    assign push       = fr_valid_reg && !full;
    assign push_sym   = fr_sym_reg;
    assign accept     = char_valid && !char_stall;

    always_comb
    begin
        fr_valid_next = fr_valid_reg;
        if (accept)
        begin
            fr_valid_next = 1'b1;
        end
        else if (push)
        begin
            fr_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    // classify on the way in
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fr_sym_reg <= sextet_of(code_char);
        end
    end

endmodule

FILE: rtl/b64d_queue.sv
module b64d_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64d_pkg::sym_t push_sym,
    output logic           full,
    input  logic           pop,
    output b64d_pkg::sym_t head_sym,
    output logic           empty
);
    import b64d_pkg::*;

    sym_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_sym = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_sym;
        end
    end

endmodule

FILE: rtl/b64d_back.sv
module b64d_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  b64d_pkg::sym_t                head_sym,
    input  logic                          empty,
    output logic                          pop,
    output logic [7:0]                    data_byte,
    output logic                          byte_valid,
    output logic                          end_of_message,
    output logic [b64d_pkg::COUNT_W-1:0]  total_bytes,
    output logic                          result_valid,
    input  logic                          result_stall
);
    import b64d_pkg::*;

    logic [1:0]          pos_reg;
    logic [1:0]          pos_next;
    logic [SEXTET_W-1:0] held_reg;
    logic [SEXTET_W-1:0] held_next;
    logic [COUNT_W-1:0]  cnt_reg;
    logic [COUNT_W-1:0]  cnt_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    logic [7:0]          byte_reg;
    logic [7:0]          byte_next;
    logic                bvalid_reg;
    logic                bvalid_next;
    logic                eom_reg;
    logic                eom_next;
    logic [COUNT_W-1:0]  total_reg;
    logic [COUNT_W-1:0]  total_next;
    logic                out_free;
    logic [7:0]          assembled;

    assign out_free = !res_valid_reg || !result_stall;
    assign pop      = !empty && out_free;

    assign data_byte      = byte_reg;
    assign byte_valid     = bvalid_reg;
    assign end_of_message = eom_reg;
    assign total_bytes    = total_reg;
    assign result_valid   = res_valid_reg;

    // join the leftover bits of the held sextet with the new one
    always_comb
    begin
        case (pos_reg)
            2'd1:    assembled = {held_reg, head_sym.sextet[5:4]};
            2'd2:    assembled = {held_reg[3:0], head_sym.sextet[5:2]};
            2'd3:    assembled = {held_reg[1:0], head_sym.sextet};
            default: assembled = '0;
        endcase
    end

    always_comb
    begin
        pos_next       = pos_reg;
        held_next      = held_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_valid_reg;
        byte_next      = byte_reg;
        bvalid_next    = bvalid_reg;
        eom_next       = eom_reg;
        total_next     = total_reg;
        if (pop)
        begin
            if (head_sym.is_end)
            begin
                res_valid_next = 1'b1;
                byte_next      = '0;
                bvalid_next    = 1'b0;
                eom_next       = 1'b1;
                total_next     = cnt_reg;
                pos_next       = POS_FIRST;
                held_next      = '0;
                cnt_next       = '0;
            end
            else
            begin
                held_next = head_sym.sextet;
                pos_next  = pos_reg + 1'b1;
                if (pos_reg == POS_FIRST)
                begin
                    // first sextet of a group: hold, no byte yet
                    res_valid_next = 1'b0;
                end
                else
                begin
                    res_valid_next = 1'b1;
                    byte_next      = assembled;
                    bvalid_next    = 1'b1;
                    eom_next       = 1'b0;
                    total_next     = '0;
                    if (cnt_reg != COUNT_MAX)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_FIRST;
            held_reg      <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            held_reg      <= held_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        bvalid_reg <= bvalid_next;
        eom_reg   <= eom_next;
        total_reg <= total_next;
    end

`ifndef SYNTHESIS
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (byte_valid != end_of_message))
        else $error("result is neither a byte nor an end, or both");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_sym.is_end) |=> (pos_reg == POS_FIRST && cnt_reg == '0))
        else $error("group state not cleared after end of message");

    a_byte_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !head_sym.is_end && pos_reg != POS_FIRST) |=> (result_valid && byte_valid))
        else $error("sextet at inner group position gave no byte");

    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && byte_valid) |-> (total_bytes == '0))
        else $error("byte result carries a count");
`endif

endmodule

FILE: rtl/base64_stream_decoder_core.sv
// Streaming base64 decoder, one character word in, at most one result word out.
// Input channel: code_char with char_valid / char_stall. Any character outside
// the standard alphabet (A-Z, a-z, 0-9, '+', '/'), '=' and NUL included, ends
// the message.
// Output channel: data_byte, byte_valid, end_of_message, total_bytes with
// result_valid / result_stall. Sextets at group positions 1, 2 and 3 each give
// a byte word; the first sextet of a group gives nothing. The terminator gives
// an end word carrying the saturating byte count, then the count and group
// position clear. A lone trailing sextet is dropped.
// Throughput: one character per clock, sustained, as long as result_stall is
// low. A character passes through the input register, the 4-word queue and the
// output register before its result is presented.
// While the receiver stalls, the queue and input register keep absorbing
// characters (up to five); char_stall rises only once they are full.
// Reset (rst_n, asynchronous, active low) empties the queue, drops any pending
// result and clears group position, held sextet and count.
module base64_stream_decoder_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [b64d_pkg::CHAR_W-1:0]   code_char,
    input  logic                          char_valid,
    output logic                          char_stall,
    output logic [7:0]                    data_byte,
    output logic                          byte_valid,
    output logic                          end_of_message,
    output logic [b64d_pkg::COUNT_W-1:0]  total_bytes,
    output logic                          result_valid,
    input  logic                          result_stall
);
    import b64d_pkg::*;

    sym_t push_sym;
    sym_t head_sym;
    logic push;
    logic pop;
    logic full;
    logic empty;

    b64d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_char  (code_char),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .push_sym   (push_sym),
        .push       (push),
        .full       (full)
    );

    b64d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_sym (push_sym),
        .full     (full),
        .pop      (pop),
        .head_sym (head_sym),
        .empty    (empty)
    );

    b64d_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_sym       (head_sym),
        .empty          (empty),
        .pop            (pop),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .total_bytes    (total_bytes),
        .result_valid   (result_valid),
        .result_stall   (result_stall)
    );

endmodule

FILE: tb/sv/b64d_stream_checker.sv
module b64d_stream_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [b64d_pkg::CHAR_W-1:0]   code_char,
    input  logic                          char_valid,
    input  logic                          char_stall,
    input  logic [7:0]                    data_byte,
    input  logic                          byte_valid,
    input  logic                          end_of_message,
    input  logic [b64d_pkg::COUNT_W-1:0]  total_bytes,
    input  logic                          result_valid,
    input  logic                          result_stall,
    output int                            mismatches,
    output int                            words_pending
);

    localparam logic [1:0] GRP_FIRST  = b64d_pkg::POS_FIRST;
    localparam logic [1:0] GRP_SECOND = 2'd1;
    localparam logic [1:0] GRP_THIRD  = 2'd2;
    localparam logic [1:0] GRP_FOURTH = 2'd3;

    typedef struct packed {
        logic [7:0]                   data_byte;
        logic                         byte_valid;
        logic                         end_of_message;
        logic [b64d_pkg::COUNT_W-1:0] total_bytes;
    } decoded_word_t;

    decoded_word_t                expected_words[$];
    logic [1:0]                   grp_pos;
    logic [5:0]                   held_bits;
    logic [b64d_pkg::COUNT_W-1:0] msg_bytes;

    initial mismatches = 0;

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [5:0]    sx;
        logic          is_term;
        decoded_word_t w;
        decoded_word_t want;

        if (!rst_n)
        begin
            grp_pos       = GRP_FIRST;
            held_bits     = '0;
            msg_bytes     = '0;
            expected_words.delete();
            words_pending <= 0;
        end
        else
        begin
            if (char_valid && !char_stall)
            begin
                is_term = 1'b0;
                sx      = '0;
                if (code_char >= "A" && code_char <= "Z")
                    sx = 6'(code_char - "A");
                else if (code_char >= "a" && code_char <= "z")
                    sx = 6'(code_char - "a" + 8'd26);
                else if (code_char >= "0" && code_char <= "9")
                    sx = 6'(code_char - "0" + 8'd52);
                else if (code_char == "+")
                    sx = 6'd62;
                else if (code_char == "/")
                    sx = 6'd63;
                else
                    is_term = 1'b1;

                w = '0;
                if (is_term)
                begin
                    // report the count, then start a fresh message
                    w.end_of_message = 1'b1;
                    w.total_bytes    = msg_bytes;
                    grp_pos          = GRP_FIRST;
                    held_bits        = '0;
                    msg_bytes        = '0;
                    expected_words.push_back(w);
                end
                else if (grp_pos == GRP_FIRST)
                begin
                    held_bits = sx;
                    grp_pos   = GRP_SECOND;
                end
                else
                begin
                    case (grp_pos)
                        GRP_SECOND:
                        begin
                            w.data_byte = {held_bits, sx[5:4]};
                            grp_pos     = GRP_THIRD;
                        end
                        GRP_THIRD:
                        begin
                            w.data_byte = {held_bits[3:0], sx[5:2]};
                            grp_pos     = GRP_FOURTH;
                        end
                        default:
                        begin
                            w.data_byte = {held_bits[1:0], sx};
                            grp_pos     = GRP_FIRST;
                        end
                    endcase
                    w.byte_valid = 1'b1;
                    held_bits    = sx;
                    if (msg_bytes != b64d_pkg::COUNT_MAX)
                        msg_bytes = msg_bytes + 1'b1;
                    expected_words.push_back(w);
                end
            end

            if (result_valid && !result_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: no word expected, got data %0h valid %0b end %0b count %0h",
                             $time, data_byte, byte_valid, end_of_message, total_bytes);
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("data_byte", 32'(want.data_byte), 32'(data_byte));
                    check_field("byte_valid", 32'(want.byte_valid), 32'(byte_valid));
                    check_field("end_of_message", 32'(want.end_of_message),
                                32'(end_of_message));
                    check_field("total_bytes", want.total_bytes, total_bytes);
                end
            end

            words_pending <= expected_words.size();
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;

    localparam logic [7:0] PAD_CHAR    = "=";
    localparam logic [7:0] NUL_CHAR    = 8'h00;
    localparam int         HOLD_CYCLES = 80;
    localparam int         STALL_LIMIT = 3000;
    localparam int         DRAIN_WAIT  = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [7:0]  code_char = '0;
    logic        char_valid = 1'b0;
    logic        char_stall;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        end_of_message;
    logic [31:0] total_bytes;
    logic        result_valid;
    logic        result_stall = 1'b0;

    int   mismatches;
    int   words_pending;
    int   chars_sent = 0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_done;
    int   hold_count;
    int   quiet_cycles;

    always #5 clk = ~clk;

    base64_stream_decoder_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .code_char      (code_char),
        .char_valid     (char_valid),
        .char_stall     (char_stall),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .total_bytes    (total_bytes),
        .result_valid   (result_valid),
        .result_stall   (result_stall)
    );

    b64d_stream_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .code_char      (code_char),
        .char_valid     (char_valid),
        .char_stall     (char_stall),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .total_bytes    (total_bytes),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .mismatches     (mismatches),
        .words_pending  (words_pending)
    );

    // Receiver: random stalls, plus one long hold-off when requested
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_stall <= 1'b0;
            hold_count   <= 0;
            hold_done    <= 1'b0;
        end
        else if (hold_req && !hold_done) begin
            result_stall <= 1'b1;
            hold_count   <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end
        else begin
            result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            quiet_cycles <= 0;
        end
        else begin
            if ((char_valid && !char_stall) || (result_valid && !result_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("base64_stream_decoder_core regression: fail");
                $finish;
            end
        end
    end

    // Offer one word and hold it until taken; call at a rising edge
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        code_char  <= c;
        char_valid <= 1'b1;
        do @(posedge clk); while (char_stall);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Well-formed message with random content and a random terminator
    task automatic send_message();
        int         len;
        logic [5:0] sx;
        logic [7:0] c;

        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
        for (int i = 0; i < len; i++) begin
            sx = 6'($urandom_range(0, 63));
            if (sx < 26)
                c = 8'("A" + sx);
            else if (sx < 52)
                c = 8'("a" + sx - 26);
            else if (sx < 62)
                c = 8'("0" + sx - 52);
            else if (sx == 62)
                c = "+";
            else
                c = "/";
            send_char(c);
        end
        case ($urandom_range(0, 3))
            0, 1: c = PAD_CHAR;
            2: c = NUL_CHAR;
            default:
            begin
                do c = 8'($urandom_range(0, 255));
                while ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
                       (c >= "0" && c <= "9") || c == "+" || c == "/");
            end
        endcase
        send_char(c);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_chance,
                             input bit with_hold, input int n_chars);
        int stop_at;

        send_idle_pct = idle_pct;
        stall_pct    <= stall_chance;
        if (with_hold)
            hold_req <= 1'b1;
        stop_at = chars_sent + n_chars;
        while (chars_sent < stop_at) begin
            // mostly clean messages, some raw noise bytes
            if ($urandom_range(0, 7) == 0)
                send_char(8'($urandom_range(0, 255)));
            else
                send_message();
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("TWFu=");
        send_text("////");
        send_char(NUL_CHAR);
        send_text("AAAA+9azQ");
        send_char(8'hFF);
        send_char(PAD_CHAR);
        send_text("TWE");
        send_char(8'h7F);

        run_phase(0, 0, 1'b0, 115);
        run_phase(65, 0, 1'b0, 115);
        run_phase(0, 65, 1'b0, 115);
        run_phase(24, 24, 1'b0, 115);
        run_phase(0, 0, 1'b1, 115);
        run_phase(0, 0, 1'b0, 115);

        char_valid <= 1'b0;
        while (words_pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("base64_stream_decoder_core regression: pass");
        else
            $display("base64_stream_decoder_core regression: fail");
        $finish;
    end

endmodule
